// ===== rtl/core/avctp_pkg.sv =====
// ----------------------------------------------------------------------------
// AVCTP fragmenter package
// Shared constants and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package avctp_pkg;

  localparam int MTU_W   = 11;
  localparam int LEN_W   = 16;
  localparam int PID_W   = 16;
  localparam int LABEL_W = 4;
  localparam int CR_W    = 2;
  localparam int KIND_W  = 2;
  localparam int HIDX_W  = 2;

  localparam logic [MTU_W-1:0] MTU_RESET = 11'd48;
  localparam logic [MTU_W-1:0] MTU_MIN   = 11'd5;

  localparam logic [MTU_W-1:0] HDR_LEN_SINGLE = 11'd3;
  localparam logic [MTU_W-1:0] HDR_LEN_START  = 11'd4;
  localparam logic [MTU_W-1:0] HDR_LEN_FOLLOW = 11'd1;

  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

  // dividend is len + 4 - mtu, up to 17 bits
  localparam int DIVD_W = LEN_W + 1;
  localparam int DCNT_W = 5;
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIVD_W);

  typedef struct packed {
    logic              capture;     // latch the accepted input item
    logic              drop_msg;    // zero-length first byte
    logic              open_single;
    logic              open_start;  // also loads the divider
    logic              div_step;
    logic              div_finish;  // packet count from quotient/remainder
    logic              open_follow; // continue or end packet
    logic              emit_hdr;
    logic              emit_data;
    logic [HIDX_W-1:0] hidx;        // header byte index for emit_hdr
  } avctp_cmd_t;

  typedef struct packed {
    logic first;
    logic len_zero;
    logic fits_single;
    logic in_msg;
    logic pbl_zero;
    logic div_done;
    logic out_free;
    logic hdr_last;
  } avctp_sts_t;

endpackage

// ===== rtl/core/avctp_dp.sv =====
// ----------------------------------------------------------------------------
// AVCTP fragmenter datapath
// Item capture, message state, packet count divider, header byte mux and
// the output register.
// ----------------------------------------------------------------------------
module avctp_dp
  import avctp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  avctp_cmd_t         cmd,
  output avctp_sts_t         sts,
  input  logic [7:0]         in_byte,
  input  logic               in_first,
  input  logic [LEN_W-1:0]   in_len,
  input  logic [LABEL_W-1:0] in_label,
  input  logic [CR_W-1:0]    in_cr,
  input  logic [PID_W-1:0]   in_pid,
  input  logic               cfg_we,
  input  logic [MTU_W-1:0]   cfg_mtu,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_plast,
  output logic               out_mlast,
  output logic [KIND_W-1:0]  out_kind
);

  logic [MTU_W-1:0]   mtu_r;
  logic [MTU_W-1:0]   mtu_eff;
  logic [MTU_W-1:0]   div_d;

  // captured item
  logic [7:0]         it_byte_r;
  logic               it_first_r;
  logic [LEN_W-1:0]   it_len_r;
  logic [LABEL_W-1:0] it_label_r;
  logic [CR_W-1:0]    it_cr_r;
  logic [PID_W-1:0]   it_pid_r;

  // message state
  logic [LEN_W-1:0]   br_r;
  logic [MTU_W-1:0]   pbl_r;
  logic [KIND_W-1:0]  kind_r;
  logic [LABEL_W-1:0] label_r;
  logic [CR_W-1:0]    cr_r;
  logic [PID_W-1:0]   pid_r;
  logic [7:0]         fcnt_r;
  logic               in_msg_r;

  // divider
  logic [DIVD_W-1:0]  div_q_r;
  logic [MTU_W-1:0]   div_rem_r;
  logic [DCNT_W-1:0]  div_cnt_r;
  logic [MTU_W:0]     rem_sh;
  logic               div_ge;
  logic [MTU_W:0]     rem_sub;
  logic [DIVD_W-1:0]  rest;

  // output register
  logic               ov_r;
  logic [7:0]         ob_r;
  logic               opl_r;
  logic               oml_r;
  logic [KIND_W-1:0]  ok_r;

  logic [7:0]         hdr_byte;
  logic [MTU_W-1:0]   pbl_dec;
  logic [LEN_W-1:0]   br_dec;
  logic               out_free;

  assign mtu_eff = (mtu_r < MTU_MIN) ? MTU_MIN : mtu_r;
  assign div_d   = mtu_eff - HDR_LEN_FOLLOW;
  assign rest    = {1'b0, it_len_r} + DIVD_W'(HDR_LEN_START) - DIVD_W'(mtu_eff);

  assign rem_sh  = {div_rem_r, div_q_r[DIVD_W-1]};
  assign div_ge  = rem_sh >= {1'b0, div_d};
  assign rem_sub = rem_sh - {1'b0, div_d};

  assign pbl_dec  = pbl_r - MTU_W'(1);
  assign br_dec   = br_r - LEN_W'(1);
  assign out_free = !ov_r || out_ready;

  always_comb begin
    hdr_byte = {label_r, kind_r, cr_r};
    case (cmd.hidx)
      2'd0: hdr_byte = {label_r, kind_r, cr_r};
      2'd1: hdr_byte = (kind_r == KIND_START) ? fcnt_r : pid_r[15:8];
      2'd2: hdr_byte = (kind_r == KIND_START) ? pid_r[15:8] : pid_r[7:0];
      2'd3: hdr_byte = pid_r[7:0];
      default: hdr_byte = {label_r, kind_r, cr_r};
    endcase
  end

  always_comb begin
    sts.first       = it_first_r;
    sts.len_zero    = it_len_r == '0;
    sts.fits_single = {1'b0, it_len_r} <= (DIVD_W'(mtu_eff) - DIVD_W'(HDR_LEN_SINGLE));
    sts.in_msg      = in_msg_r;
    sts.pbl_zero    = pbl_r == '0;
    sts.div_done    = div_cnt_r == DIV_STEPS;
    sts.out_free    = out_free;
    case (kind_r)
      KIND_SINGLE: sts.hdr_last = cmd.hidx == 2'd2;
      KIND_START:  sts.hdr_last = cmd.hidx == 2'd3;
      default:     sts.hdr_last = cmd.hidx == 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r <= MTU_RESET;
    end else if (cfg_we) begin
      mtu_r <= cfg_mtu;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_byte_r  <= in_byte;
      it_first_r <= in_first;
      it_len_r   <= in_len;
      it_label_r <= in_label;
      it_cr_r    <= in_cr;
      it_pid_r   <= in_pid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.open_start) begin
      div_q_r   <= rest;
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[DIVD_W-2:0], div_ge};
      div_rem_r <= div_ge ? rem_sub[MTU_W-1:0] : rem_sh[MTU_W-1:0];
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_r     <= '0;
      pbl_r    <= '0;
      kind_r   <= KIND_SINGLE;
      label_r  <= '0;
      cr_r     <= '0;
      pid_r    <= '0;
      fcnt_r   <= '0;
      in_msg_r <= 1'b0;
    end else begin
      if (cmd.drop_msg) begin
        in_msg_r <= 1'b0;
        br_r     <= '0;
        pbl_r    <= '0;
      end
      if (cmd.open_single || cmd.open_start) begin
        label_r  <= it_label_r;
        cr_r     <= it_cr_r;
        pid_r    <= it_pid_r;
        br_r     <= it_len_r;
        in_msg_r <= 1'b1;
      end
      if (cmd.open_single) begin
        kind_r <= KIND_SINGLE;
        pbl_r  <= it_len_r[MTU_W-1:0];
        fcnt_r <= '0;
      end
      if (cmd.open_start) begin
        kind_r <= KIND_START;
        pbl_r  <= mtu_eff - HDR_LEN_START;
      end
      if (cmd.div_finish) begin
        // packets = full follow-ups + start + partial tail, modulo 256
        fcnt_r <= div_q_r[7:0] + 8'd1 + {7'd0, div_rem_r != '0};
      end
      if (cmd.open_follow) begin
        if (br_r > LEN_W'(div_d)) begin
          kind_r <= KIND_CONT;
          pbl_r  <= div_d;
        end else begin
          kind_r <= KIND_END;
          pbl_r  <= br_r[MTU_W-1:0];
        end
      end
      if (cmd.emit_data) begin
        br_r <= br_dec;
        if (br_dec == '0) begin
          in_msg_r <= 1'b0;
          pbl_r    <= '0;
        end else begin
          pbl_r <= pbl_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_hdr || cmd.emit_data) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hdr) begin
      ob_r  <= hdr_byte;
      opl_r <= 1'b0;
      oml_r <= 1'b0;
      ok_r  <= kind_r;
    end else if (cmd.emit_data) begin
      ob_r  <= it_byte_r;
      opl_r <= pbl_dec == '0;
      oml_r <= br_dec == '0;
      ok_r  <= kind_r;
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_plast = opl_r;
  assign out_mlast = oml_r;
  assign out_kind  = ok_r;

endmodule

// ===== rtl/core/avctp_ctrl.sv =====
// ----------------------------------------------------------------------------
// AVCTP fragmenter controller
// Sequences one input byte: evaluate, divide for the packet count, emit
// header bytes, emit the payload byte.
// ----------------------------------------------------------------------------
module avctp_ctrl
  import avctp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  avctp_sts_t sts,
  output avctp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_HDR,
    ST_DATA
  } state_t;

  state_t            state_r, state_nxt;
  logic [HIDX_W-1:0] hidx_r, hidx_nxt;

  assign in_ready = state_r == ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    hidx_nxt  = hidx_r;
    cmd       = '0;
    cmd.hidx  = hidx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        hidx_nxt = '0;
        if (sts.first) begin
          if (sts.len_zero) begin
            cmd.drop_msg = 1'b1;
            state_nxt    = ST_IDLE;
          end else if (sts.fits_single) begin
            cmd.open_single = 1'b1;
            state_nxt       = ST_HDR;
          end else begin
            cmd.open_start = 1'b1;
            state_nxt      = ST_DIV;
          end
        end else if (!sts.in_msg) begin
          state_nxt = ST_IDLE;
        end else if (sts.pbl_zero) begin
          cmd.open_follow = 1'b1;
          state_nxt       = ST_HDR;
        end else begin
          state_nxt = ST_DATA;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_finish = 1'b1;
          state_nxt      = ST_HDR;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_HDR: begin
        if (sts.out_free) begin
          cmd.emit_hdr = 1'b1;
          if (sts.hdr_last) begin
            state_nxt = ST_DATA;
          end else begin
            hidx_nxt = hidx_r + HIDX_W'(1);
          end
        end
      end
      ST_DATA: begin
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      hidx_r  <= hidx_nxt;
    end
  end

endmodule

// ===== rtl/core/avctp_message_fragmenter.sv =====
// ----------------------------------------------------------------------------
// AVCTP message fragmenter
// Cuts a byte-wise message into link packets no larger than the peer MTU.
// ----------------------------------------------------------------------------
// Each payload byte is taken on the input stream and turned into its packet
// bytes: header bytes (three for a single packet, four for a start packet,
// one for continue and end packets) ahead of the packet's first data byte,
// then the data byte itself. The first byte of a message that needs
// fragmenting also passes through the bit-serial divider that computes the
// packet count, one quotient bit per cycle. The output register lets the next
// byte be processed while a result waits; back-pressure on the output
// stretches the header and data emit steps. The MTU register is written over
// the cfg port, always ready; the user must write it only while the block is
// idle, which the block itself does not enforce. Values below 5 act as 5.
// ----------------------------------------------------------------------------
module avctp_message_fragmenter
  import avctp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: payload_byte[7:0], message_length[23:8], transaction_label[27:24],
  //           cr_ipid[29:28], profile_id[45:30], zero pad[47:46]
  input  logic [47:0] in_tdata,
  // in_tuser: first_of_message[0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: out_byte[7:0]
  output logic [7:0]  out_tdata,
  // out_tuser: message_last[0], packet_kind[2:1]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [10:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  avctp_cmd_t        cmd;
  avctp_sts_t        sts;
  logic              mlast;
  logic [KIND_W-1:0] kind;

  assign cfg_ready = 1'b1;

  avctp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  avctp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_tdata[7:0]),
    .in_first  (in_tuser),
    .in_len    (in_tdata[23:8]),
    .in_label  (in_tdata[27:24]),
    .in_cr     (in_tdata[29:28]),
    .in_pid    (in_tdata[45:30]),
    .cfg_we    (cfg_valid),
    .cfg_mtu   (cfg_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_plast (out_tlast),
    .out_mlast (mlast),
    .out_kind  (kind)
  );

  assign out_tuser = {kind, mlast};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AVCTP message fragmenter testbench
// Streams messages byte by byte into the fragmenter, predicts every packet
// byte (headers and data) and checks the output stream in order. Runs a short
// directed sequence, then random phases at several MTU settings with steady,
// bursty or sparse input and an always ready, stalling or choked output.
// ----------------------------------------------------------------------------
module tb;
  import avctp_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS   = 45;

  typedef struct {
    logic [7:0]  payload;
    bit          first;
    logic [15:0] len;
    logic [3:0]  label;
    logic [1:0]  cr;
    logic [15:0] pid;
    bit          drain_before; // hold this item until the output has drained
  } msg_item_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              plast;
    logic              mlast;
    logic [KIND_W-1:0] kind;
  } pkt_byte_t;

  typedef enum int {SEND_STEADY, SEND_BURSTY, SEND_SPARSE} send_mode_e;
  typedef enum int {RDY_ALWAYS, RDY_PATTERN, RDY_CHOKED} rdy_mode_e;

  logic        clk;
  logic        rst_n = 1'b0;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [10:0] cfg_data = MTU_RESET;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;

  // fragmenter state as predicted
  logic [MTU_W-1:0]   mtu_reg = MTU_RESET;
  logic [LEN_W-1:0]   left_in_msg = '0;
  logic [MTU_W-1:0]   left_in_pkt = '0;
  logic [KIND_W-1:0]  pkt_kind_q = KIND_SINGLE;
  logic [LABEL_W-1:0] hdr_label = '0;
  logic [CR_W-1:0]    hdr_cr = '0;
  logic [PID_W-1:0]   hdr_pid = '0;
  logic [7:0]         pkt_count = '0;
  bit                 open_msg = 1'b0;

  msg_item_t  pending_items[$];
  pkt_byte_t  expected_bytes[$];
  msg_item_t  item_on_bus;
  int         queued_count = 0;
  int         accepted_count = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  send_mode_e sender_mode = SEND_BURSTY;
  rdy_mode_e  ready_mode = RDY_PATTERN;

  avctp_message_fragmenter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  task automatic expect_byte(input logic [7:0] d, input logic plast, input logic mlast);
    pkt_byte_t b;
    b = '{d, plast, mlast, pkt_kind_q};
    expected_bytes.push_back(b);
  endtask

  task automatic expect_header();
    expect_byte({hdr_label, pkt_kind_q, hdr_cr}, 1'b0, 1'b0);
    if (pkt_kind_q == KIND_START) expect_byte(pkt_count, 1'b0, 1'b0);
    if (pkt_kind_q == KIND_START || pkt_kind_q == KIND_SINGLE) begin
      expect_byte(hdr_pid[15:8], 1'b0, 1'b0);
      expect_byte(hdr_pid[7:0], 1'b0, 1'b0);
    end
  endtask

  task automatic fragment_byte(input msg_item_t it);
    int m;
    int len;
    int rest;
    int cnt;
    m = (mtu_reg < MTU_MIN) ? int'(MTU_MIN) : int'(mtu_reg);
    if (it.first) begin
      len = int'(it.len);
      if (len == 0) begin
        open_msg = 1'b0;
        left_in_msg = '0;
        left_in_pkt = '0;
        return;
      end
      hdr_label = it.label;
      hdr_cr = it.cr;
      hdr_pid = it.pid;
      left_in_msg = it.len;
      if (len <= m - int'(HDR_LEN_SINGLE)) begin
        pkt_kind_q = KIND_SINGLE;
        left_in_pkt = MTU_W'(len);
        pkt_count = '0;
      end else begin
        // count covers the start packet too; keeps only 8 bits
        rest = len + int'(HDR_LEN_START) - m;
        cnt = rest / (m - 1) + 1;
        if (rest % (m - 1) != 0) cnt++;
        pkt_kind_q = KIND_START;
        left_in_pkt = MTU_W'(m - int'(HDR_LEN_START));
        pkt_count = 8'(cnt);
      end
      open_msg = 1'b1;
      expect_header();
    end else begin
      if (!open_msg) return;
      if (left_in_pkt == '0) begin
        if (int'(left_in_msg) > m - int'(HDR_LEN_FOLLOW)) begin
          pkt_kind_q = KIND_CONT;
          left_in_pkt = MTU_W'(m - int'(HDR_LEN_FOLLOW));
        end else begin
          pkt_kind_q = KIND_END;
          left_in_pkt = MTU_W'(left_in_msg);
        end
        expect_header();
      end
    end
    left_in_pkt = left_in_pkt - MTU_W'(1);
    left_in_msg = left_in_msg - LEN_W'(1);
    expect_byte(it.payload, left_in_pkt == '0, left_in_msg == '0);
    if (left_in_msg == '0) begin
      open_msg = 1'b0;
      left_in_pkt = '0;
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic msg_item_t make_item(bit first, logic [15:0] len, logic [3:0] label,
                                          logic [1:0] cr, logic [15:0] pid,
                                          logic [7:0] payload);
    msg_item_t it;
    it.first = first;
    it.len = len;
    it.label = label;
    it.cr = cr;
    it.pid = pid;
    it.payload = payload;
    it.drain_before = 1'b0;
    return it;
  endfunction

  // header fields of a follow byte are don't-care, so they are random too
  function automatic msg_item_t random_item(bit first, logic [15:0] len);
    return make_item(first, first ? len : 16'($urandom), 4'($urandom), 2'($urandom),
                     16'($urandom), 8'($urandom));
  endfunction

  task automatic queue_item(input msg_item_t it);
    it.drain_before = (queued_count % 97 == 50) || ($urandom_range(0, 63) == 0);
    pending_items.push_back(it);
    queued_count++;
  endtask

  task automatic gen_phase(input logic [10:0] mtu_val, input int n_items);
    int m;
    int made;
    int len;
    int pick;
    int extra;
    int cap;
    int bounds[5];
    m = (mtu_val < MTU_MIN) ? int'(MTU_MIN) : int'(mtu_val);
    // lengths at the single/start edge and around exactly full end packets
    bounds = '{m - 3, m - 2, 2 * m - 5, 2 * m - 4, 3 * m - 6};
    cap = (3 * m > 150) ? 150 : 3 * m;
    made = 0;
    while (made < n_items) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 8) begin
        queue_item(random_item(1'b0, 16'd0));
        made++;
      end else if (pick < 12) begin
        queue_item(random_item(1'b1, 16'd0));
        made++;
      end else if (pick < 24) begin
        // long message cut short by whatever first byte comes next
        queue_item(random_item(1'b1, 16'($urandom_range(1, 65535))));
        extra = int'($urandom_range(0, 4));
        repeat (extra) queue_item(random_item(1'b0, 16'd0));
        made += extra + 1;
      end else begin
        len = int'($urandom_range(1, cap));
        if (pick < 48) begin
          len = bounds[$urandom_range(0, 4)];
          if (len < 1 || len > 400) len = int'($urandom_range(1, 40));
        end
        // keep the phase near its item budget
        if (len > n_items - made) len = n_items - made;
        queue_item(random_item(1'b1, 16'(len)));
        repeat (len - 1) queue_item(random_item(1'b0, 16'd0));
        made += len;
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_count != queued_count || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [10:0] phase_mtu[9];
    phase_mtu = '{11'd5, 11'd1024, 11'd0, 11'd2047, 11'd4, 11'd13, 11'd0, 11'd0, MTU_RESET};
    phase_mtu[6] = 11'($urandom_range(5, 64));
    phase_mtu[7] = 11'($urandom_range(5, 1024));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at the reset MTU of 48
    queue_item(make_item(1'b0, 16'hFFFF, 4'hF, 2'd3, 16'hFFFF, 8'hFF));   // stray byte
    queue_item(make_item(1'b1, 16'd0, 4'hF, 2'd3, 16'hFFFF, 8'hAA));      // zero length
    queue_item(make_item(1'b1, 16'd1, 4'hF, 2'd3, 16'hFFFF, 8'h00));
    queue_item(make_item(1'b1, 16'd3, 4'h0, 2'd0, 16'h0000, 8'hFF));
    queue_item(random_item(1'b0, 16'd0));
    queue_item(random_item(1'b0, 16'd0));
    // start packet with wrapped count, then restarts
    queue_item(make_item(1'b1, 16'hFFFF, 4'h5, 2'd2, 16'h1234, 8'h11));
    queue_item(make_item(1'b1, 16'd65531, 4'hA, 2'd1, 16'hA5C3, 8'h22));
    queue_item(make_item(1'b1, 16'd2, 4'h3, 2'd0, 16'h8001, 8'h33));
    queue_item(random_item(1'b0, 16'd0));
    queue_item(random_item(1'b0, 16'd0));                                  // stray byte
    // largest single packet, dropped by a zero-length first byte
    queue_item(make_item(1'b1, 16'd45, 4'h9, 2'd3, 16'h00FF, 8'h44));
    queue_item(random_item(1'b0, 16'd0));
    queue_item(make_item(1'b1, 16'd0, 4'h6, 2'd2, 16'hFF00, 8'h55));
    queue_item(random_item(1'b0, 16'd0));                                  // stray byte
    // smallest start packet, then a restart into a single
    queue_item(make_item(1'b1, 16'd46, 4'hC, 2'd2, 16'h5AA5, 8'h66));
    queue_item(make_item(1'b1, 16'd1, 4'h1, 2'd1, 16'h7FFE, 8'h77));
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      cfg_data <= phase_mtu[p];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;
      mtu_reg = phase_mtu[p];
      sender_mode = send_mode_e'(p % 3);
      ready_mode = rdy_mode_e'((p / 3) % 3);
      gen_phase(phase_mtu[p], PHASE_ITEMS);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : driver
    bit send;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        fragment_byte(item_on_bus);
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        send = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain_before && expected_bytes.size() > 0)) begin
          item_on_bus = pending_items.pop_front();
          send = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            case (sender_mode)
              SEND_STEADY: begin
                burst_left = 64;
                gap_left = 0;
              end
              SEND_BURSTY: begin
                burst_left = int'($urandom_range(1, 16));
                gap_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(5, 20))
                                                       : int'($urandom_range(0, 3));
              end
              default: begin
                burst_left = int'($urandom_range(1, 4));
                gap_left = int'($urandom_range(1, 8));
              end
            endcase
          end
        end
        in_tvalid <= send;
        if (send) begin
          in_tdata <= {2'b00, item_on_bus.pid, item_on_bus.cr, item_on_bus.label,
                       item_on_bus.len, item_on_bus.payload};
          in_tuser <= item_on_bus.first;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_pattern == 16'h0000 || $urandom_range(0, 31) == 0) begin
        stall_pattern = (ready_mode == RDY_CHOKED) ? (16'($urandom) & 16'($urandom)) | 16'h0001
                                                   : 16'($urandom);
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      out_tready <= (ready_mode == RDY_ALWAYS) || stall_pattern[0];
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : monitor
    pkt_byte_t got;
    pkt_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tlast, out_tuser[0], out_tuser[2:1]};
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected out transfer: expected none, actual byte=%h last=%b",
                 $time, got.data, got.plast, " msg_last=%b kind=%0d", got.mlast, got.kind);
      end else begin
        want = expected_bytes.pop_front();
        if (got.data !== want.data || got.plast !== want.plast ||
            got.mlast !== want.mlast || got.kind !== want.kind) begin
          mismatch_count++;
          $display("%0t: out mismatch: expected byte=%h last=%b msg_last=%b kind=%0d,",
                   $time, want.data, want.plast, want.mlast, want.kind,
                   " actual byte=%h last=%b msg_last=%b kind=%0d",
                   got.data, got.plast, got.mlast, got.kind);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
